### rtl/tmaf_pkg.sv
`default_nettype none
package tmaf_pkg;

  // Fixed field widths
  localparam int unsigned CODE_W = 12;
  localparam int unsigned MV_W   = 16;
  localparam int unsigned SUM_W  = CODE_W + 2;

  // Divide by three: x * 43691 >> 17 is exact for x < 2^16
  localparam int unsigned         DIV3_SHIFT = 17;
  localparam logic [MV_W:0]       DIV3_MUL   = 17'd43691;
  localparam int unsigned         QUO_W      = SUM_W + MV_W + 1;

  // Configuration register indexes
  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic [MV_W-1:0] FULL_SCALE_RST = 16'd4620;

  // Controller to datapath commands
  typedef struct packed {
    logic insert;
    logic sum;
    logic div;
    logic mul;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
  } stat_t;

endpackage
`default_nettype wire

### rtl/tmaf_ctrl.sv
`default_nettype none
module tmaf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire tmaf_pkg::stat_t stat,
  output tmaf_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                out_valid
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Next state: a sample that closes the batch starts the result sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && stat.last) state_nxt = ST_SUM;
      end
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign cmd.insert = accept;
  assign cmd.sum    = (state_r == ST_SUM);
  assign cmd.div    = (state_r == ST_DIV);
  assign cmd.mul    = (state_r == ST_MUL);
  assign out_valid  = (state_r == ST_OUT);

endmodule
`default_nettype wire

### rtl/tmaf_dp.sv
`default_nettype none
module tmaf_dp #(
  parameter int unsigned BATCH       = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tmaf_pkg::cmd_t                    cmd,
  input  wire logic [tmaf_pkg::CODE_W-1:0]       in_sample,
  input  wire logic [tmaf_pkg::MV_W-1:0]         full_scale,
  output tmaf_pkg::stat_t                        stat,
  output logic [tmaf_pkg::CODE_W-1:0]            out_average_code,
  output logic [tmaf_pkg::MV_W-1:0]              out_voltage_mv
);

  localparam int unsigned CW      = tmaf_pkg::CODE_W;
  localparam int unsigned FW      = (BATCH > 1) ? $clog2(BATCH) : 1;
  localparam int unsigned MaskW   = (SAMPLE_BITS < CW) ? SAMPLE_BITS : CW;
  localparam logic [CW-1:0] SampleMask = {CW{1'b1}} >> (CW - MaskW);
  localparam int unsigned Mid     = BATCH / 2;
  localparam int unsigned ProdW   = CW + tmaf_pkg::MV_W;
  localparam int unsigned ScaledW = ProdW - SAMPLE_BITS;
  localparam logic [FW-1:0] LastIdx = FW'(BATCH - 1);

  logic [CW-1:0]                  srt_r [BATCH];
  logic [CW-1:0]                  srt_nxt [BATCH];
  logic [FW-1:0]                  fill_r;
  logic [BATCH-1:0]               gt;
  logic [CW-1:0]                  smp;
  logic [tmaf_pkg::SUM_W-1:0]     sum_r;
  logic [tmaf_pkg::QUO_W-1:0]     quo_r;
  logic [CW-1:0]                  avg;
  logic [CW-1:0]                  avg_r;
  logic [ProdW-1:0]               prod_r;
  logic [ScaledW-1:0]             scaled;

  assign smp       = in_sample & SampleMask;
  assign stat.last = (fill_r == LastIdx);

  // Sorted insertion: held entries above the new sample move up one place.
  // Empty places count as greater than any sample.
  always_comb begin
    for (int i = 0; i < BATCH; i++) begin
      gt[i] = (FW'(i) >= fill_r) || (srt_r[i] > smp);
    end
    for (int i = 0; i < BATCH; i++) begin
      if (!gt[i]) begin
        srt_nxt[i] = srt_r[i];
      end else if (i == 0) begin
        srt_nxt[i] = smp;
      end else if (!gt[i-1]) begin
        srt_nxt[i] = smp;
      end else begin
        srt_nxt[i] = srt_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < BATCH; i++) begin
        srt_r[i] <= srt_nxt[i];
      end
    end
  end

  // Fill count wraps after the last sample of a batch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.insert) begin
      fill_r <= stat.last ? '0 : fill_r + 1'b1;
    end
  end

  // Middle three ranks, divide by three, scale to millivolts
  assign avg = CW'(quo_r >> tmaf_pkg::DIV3_SHIFT);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= tmaf_pkg::SUM_W'(srt_r[Mid-1]) + tmaf_pkg::SUM_W'(srt_r[Mid])
             + tmaf_pkg::SUM_W'(srt_r[Mid+1]);
    end
    if (cmd.div) begin
      quo_r <= tmaf_pkg::QUO_W'(sum_r) * tmaf_pkg::QUO_W'(tmaf_pkg::DIV3_MUL);
    end
    if (cmd.mul) begin
      avg_r  <= avg;
      prod_r <= ProdW'(avg) * ProdW'(full_scale);
    end
  end

  // Saturate when the converter width is narrow
  assign scaled = ScaledW'(prod_r >> SAMPLE_BITS);

  always_comb begin
    out_average_code = avg_r;
    if (scaled > ScaledW'({tmaf_pkg::MV_W{1'b1}})) begin
      out_voltage_mv = {tmaf_pkg::MV_W{1'b1}};
    end else begin
      out_voltage_mv = tmaf_pkg::MV_W'(scaled);
    end
  end

endmodule
`default_nettype wire

### rtl/trimmed_mean_adc_filter_core.sv
`default_nettype none
// Trimmed-mean converter filter. Each request (start high while busy is low)
// carries one sample; samples are kept in a register row in ascending order,
// one insertion per request, so a sample that does not close the batch is
// taken directly and busy stays low. The sample that closes a batch of BATCH
// raises busy through the states middle-rank sum, divide by three, scale
// multiply and output; out_valid is high in the output state for exactly one
// cycle and the receiver cannot stall it. full_scale_mv is at APB byte
// address 0.
module trimmed_mean_adc_filter_core #(
  parameter int unsigned BATCH       = 10,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Sample requests
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [tmaf_pkg::CODE_W-1:0]  in_sample,
  // Results
  output logic                              out_valid,
  output logic [tmaf_pkg::CODE_W-1:0]       out_average_code,
  output logic [tmaf_pkg::MV_W-1:0]         out_voltage_mv,
  // Configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  tmaf_pkg::cmd_t       cmd;
  tmaf_pkg::stat_t      stat;
  logic [tmaf_pkg::MV_W-1:0] full_scale_r;
  logic                 reg_hit;

  // Register file: one register at word 0
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tmaf_pkg::REG_FULL_SCALE) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= tmaf_pkg::FULL_SCALE_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      full_scale_r <= pwdata[tmaf_pkg::MV_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32 - tmaf_pkg::MV_W){1'b0}}, full_scale_r} : 32'd0;

  tmaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tmaf_dp #(
    .BATCH       (BATCH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_sample        (in_sample),
    .full_scale       (full_scale_r),
    .stat             (stat),
    .out_average_code (out_average_code),
    .out_voltage_mv   (out_voltage_mv)
  );

endmodule
`default_nettype wire
